/* src/usct_pkg.sv */
// Shared types, constants and arithmetic helpers for the sphere cell tessellator.
`timescale 1ns / 1ps

package usct_pkg;

  localparam logic [2:0] REG_RADIUS   = 3'd0;
  localparam logic [2:0] REG_CENTER_X = 3'd1;
  localparam logic [2:0] REG_CENTER_Y = 3'd2;
  localparam logic [2:0] REG_CENTER_Z = 3'd3;
  localparam logic [2:0] REG_THETA_N  = 3'd4;
  localparam logic [2:0] REG_PHI_N    = 3'd5;

  localparam logic [1:0] CORNER_00 = 2'd0;
  localparam logic [1:0] CORNER_10 = 2'd1;
  localparam logic [1:0] CORNER_01 = 2'd2;
  localparam logic [1:0] CORNER_11 = 2'd3;

  localparam logic [1:0] SLOT_COS0 = 2'd0;
  localparam logic [1:0] SLOT_SIN0 = 2'd1;
  localparam logic [1:0] SLOT_COS1 = 2'd2;
  localparam logic [1:0] SLOT_SIN1 = 2'd3;

  localparam logic [31:0] COEF_A = 32'd1686629713;
  localparam logic [31:0] COEF_B = 32'd693598669;
  localparam logic [31:0] COEF_C = 32'd85569303;
  localparam logic [31:0] COEF_D = 32'd5026994;
  localparam logic [31:0] COEF_E = 32'd172272;

  typedef struct packed {
    logic signed [15:0] ct0;
    logic signed [15:0] st0;
    logic signed [15:0] ct1;
    logic signed [15:0] st1;
    logic signed [15:0] cp0;
    logic signed [15:0] sp0;
    logic signed [15:0] cp1;
    logic signed [15:0] sp1;
  } trig_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] slot;
  } sin_ctl_t;

  function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return p[61:30];
  endfunction

  function automatic logic signed [17:0] mul_round15(input logic signed [16:0] a,
                                                     input logic signed [16:0] b);
    logic        neg;
    logic [16:0] ma;
    logic [16:0] mb;
    logic [33:0] m;
    logic [17:0] mag;
    neg = a[16] ^ b[16];
    ma = a[16] ? 17'(-a) : 17'(a);
    mb = b[16] ? 17'(-b) : 17'(b);
    m = 34'(ma) * 34'(mb) + 34'd16384;
    mag = m[32:15];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [1:0] corner_of(input logic [2:0] vtx);
    case (vtx)
      3'd0: return CORNER_00;
      3'd1: return CORNER_10;
      3'd2: return CORNER_01;
      3'd3: return CORNER_01;
      3'd4: return CORNER_10;
      3'd5: return CORNER_11;
      default: return CORNER_00;
    endcase
  endfunction

endpackage

/* src/usct_sine.sv */
// Pipelined quarter-wave polynomial sine unit with a stall enable.
`timescale 1ns / 1ps

module usct_sine #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  usct_pkg::sin_ctl_t      in_ctl,
  input  logic [ANGLE_BITS-1:0]   angle,
  output usct_pkg::sin_ctl_t      out_ctl,
  output logic signed [15:0]      value
);

  localparam int SHIFT = 30 - (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-2:0] QTR = {1'b1, {(ANGLE_BITS - 2){1'b0}}};

  logic        vld [0:7];
  logic [1:0]  slot [0:7];
  logic        neg [0:6];
  logic [30:0] u [0:5];
  logic [31:0] u2 [1:4];
  logic [31:0] t [2:5];
  logic [31:0] s6;
  logic [ANGLE_BITS-2:0] rr;
  logic [32:0] rsum;
  logic [17:0] rmag;
  logic [15:0] mag;

  always_comb begin
    rr = angle[ANGLE_BITS-2] ? QTR - {1'b0, angle[ANGLE_BITS-3:0]}
                             : {1'b0, angle[ANGLE_BITS-3:0]};
    rsum = 33'(s6) + 33'd16384;
    rmag = rsum[32:15];
    mag = (rmag > 18'd32767) ? 16'd32767 : rmag[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 8; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_ctl.valid;
      for (int k = 1; k < 8; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot[0] <= in_ctl.slot;
      neg[0] <= angle[ANGLE_BITS-1];
      u[0] <= 31'(rr) << SHIFT;
      for (int k = 1; k < 8; k++) slot[k] <= slot[k-1];
      for (int k = 1; k < 7; k++) neg[k] <= neg[k-1];
      for (int k = 1; k < 6; k++) u[k] <= u[k-1];
      u2[1] <= usct_pkg::mul_q30(32'(u[0]), 32'(u[0]));
      for (int k = 2; k < 5; k++) u2[k] <= u2[k-1];
      t[2] <= usct_pkg::COEF_D - usct_pkg::mul_q30(u2[1], usct_pkg::COEF_E);
      t[3] <= usct_pkg::COEF_C - usct_pkg::mul_q30(u2[2], t[2]);
      t[4] <= usct_pkg::COEF_B - usct_pkg::mul_q30(u2[3], t[3]);
      t[5] <= usct_pkg::COEF_A - usct_pkg::mul_q30(u2[4], t[4]);
      s6 <= usct_pkg::mul_q30(32'(u[5]), t[5]);
      value <= neg[6] ? -$signed(mag) : $signed(mag);
    end
  end

  assign out_ctl.valid = vld[7];
  assign out_ctl.slot = slot[7];

endmodule

/* src/usct_front.sv */
// Front end: accepts cells, divides out the corner angles and evaluates their sines.
`timescale 1ns / 1ps

module usct_front #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [10:0]         theta_count,
  input  logic [10:0]         phi_count,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          theta_index,
  input  logic [9:0]          phi_index,
  input  logic                fifo_full,
  output logic                push,
  output usct_pkg::trig_t     push_data
);

  localparam int DW = 11 + ANGLE_BITS;
  localparam int STEP = 5;
  localparam int DCYC = (DW + STEP - 1) / STEP;
  localparam int DBITS = DCYC * STEP;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int CNTW = $clog2(DCYC + 1);
  localparam logic [ANGLE_BITS-1:0] QA = {2'b01, {(ANGLE_BITS - 2){1'b0}}};

  logic [DBITS-1:0] dvd [0:3];
  logic [DBITS-1:0] dvd_next [0:3];
  logic [CW:0]      rem [0:3];
  logic [CW:0]      rem_next [0:3];
  logic [CW-1:0]    dsr [0:1];
  logic             div_busy;
  logic             div_done;
  logic [CNTW-1:0]  div_cnt;

  logic [ANGLE_BITS-1:0] ang [0:3];
  logic             iss_busy;
  logic [1:0]       iss_slot;
  logic             take;
  logic             en;
  logic             accept;

  usct_pkg::sin_ctl_t    ctl_in;
  usct_pkg::sin_ctl_t    ctl_a;
  usct_pkg::sin_ctl_t    ctl_b;
  logic [ANGLE_BITS-1:0] ang_a;
  logic [ANGLE_BITS-1:0] ang_b;
  logic signed [15:0]    val_a;
  logic signed [15:0]    val_b;
  usct_pkg::trig_t       stage;

  function automatic logic [CW-1:0] eff_count(input logic [10:0] c);
    if (c == 11'd0) return CW'(1);
    if (32'(c) > MAX_SEGMENTS) return CW'(MAX_SEGMENTS);
    return CW'(c);
  endfunction

  assign in_ready = !div_busy && !div_done;
  assign accept = in_valid && in_ready;

  always_comb begin
    logic [CW:0]      r;
    logic [DBITS-1:0] q;
    logic [CW-1:0]    d;
    for (int l = 0; l < 4; l++) begin
      r = rem[l];
      q = dvd[l];
      d = dsr[l / 2];
      for (int k = 0; k < STEP; k++) begin
        r = {r[CW-1:0], q[DBITS-1]};
        q = q << 1;
        if (r >= {1'b0, d}) begin
          r = r - {1'b0, d};
          q[0] = 1'b1;
        end
      end
      rem_next[l] = r;
      dvd_next[l] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_cnt <= '0;
    end else begin
      if (accept) begin
        div_busy <= 1'b1;
        div_cnt <= '0;
      end else if (div_busy) begin
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == CNTW'(DCYC - 1)) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end else if (take) begin
        div_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dvd[0] <= DBITS'(theta_index) << ANGLE_BITS;
      dvd[1] <= DBITS'(11'(theta_index) + 11'd1) << ANGLE_BITS;
      dvd[2] <= DBITS'(phi_index) << (ANGLE_BITS - 1);
      dvd[3] <= DBITS'(11'(phi_index) + 11'd1) << (ANGLE_BITS - 1);
      for (int l = 0; l < 4; l++) rem[l] <= '0;
      dsr[0] <= eff_count(theta_count);
      dsr[1] <= eff_count(phi_count);
    end else if (div_busy) begin
      for (int l = 0; l < 4; l++) begin
        dvd[l] <= dvd_next[l];
        rem[l] <= rem_next[l];
      end
    end
  end

  assign en = !(ctl_a.valid && ctl_a.slot == usct_pkg::SLOT_SIN1 && fifo_full);
  assign take = div_done && (!iss_busy || (en && iss_slot == usct_pkg::SLOT_SIN1));

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_busy <= 1'b0;
      iss_slot <= usct_pkg::SLOT_COS0;
    end else if (take) begin
      iss_busy <= 1'b1;
      iss_slot <= usct_pkg::SLOT_COS0;
    end else if (iss_busy && en) begin
      iss_slot <= iss_slot + 2'd1;
      if (iss_slot == usct_pkg::SLOT_SIN1) iss_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int l = 0; l < 4; l++) ang[l] <= dvd[l][ANGLE_BITS-1:0];
    end
  end

  always_comb begin
    ctl_in.valid = iss_busy;
    ctl_in.slot = iss_slot;
    ang_a = iss_slot[1] ? ang[1] : ang[0];
    ang_b = iss_slot[1] ? ang[3] : ang[2];
    if (!iss_slot[0]) begin
      ang_a = ang_a + QA;
      ang_b = ang_b + QA;
    end
  end

  usct_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sine_theta (
    .clk(clk), .rst(rst), .en(en), .in_ctl(ctl_in), .angle(ang_a),
    .out_ctl(ctl_a), .value(val_a)
  );

  usct_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sine_phi (
    .clk(clk), .rst(rst), .en(en), .in_ctl(ctl_in), .angle(ang_b),
    .out_ctl(ctl_b), .value(val_b)
  );

  always_ff @(posedge clk) begin
    if (en && ctl_a.valid && ctl_b.valid) begin
      case (ctl_a.slot)
        usct_pkg::SLOT_COS0: begin
          stage.ct0 <= val_a;
          stage.cp0 <= val_b;
        end
        usct_pkg::SLOT_SIN0: begin
          stage.st0 <= val_a;
          stage.sp0 <= val_b;
        end
        usct_pkg::SLOT_COS1: begin
          stage.ct1 <= val_a;
          stage.cp1 <= val_b;
        end
        default: begin
          stage.st1 <= val_a;
          stage.sp1 <= val_b;
        end
      endcase
    end
  end

  always_comb begin
    push = ctl_a.valid && ctl_a.slot == usct_pkg::SLOT_SIN1 && !fifo_full;
    push_data = stage;
    push_data.st1 = val_a;
    push_data.sp1 = val_b;
  end

endmodule

/* src/usct_fifo.sv */
// Two-entry queue of per-cell sine and cosine sets between front and back end.
`timescale 1ns / 1ps

module usct_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  usct_pkg::trig_t push_data,
  input  logic            pop,
  output usct_pkg::trig_t pop_data,
  output logic            full,
  output logic            empty
);

  usct_pkg::trig_t mem [0:1];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

endmodule

/* src/usct_back.sv */
// Back end: walks the six vertices of a cell and forms normals and positions.
`timescale 1ns / 1ps

module usct_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [14:0]        sphere_radius,
  input  logic signed [15:0] center_x,
  input  logic signed [15:0] center_y,
  input  logic signed [15:0] center_z,
  input  logic               fifo_empty,
  input  usct_pkg::trig_t    fifo_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [1:0]         corner_code,
  output logic               last_vertex
);

  logic               en;
  logic [2:0]         vtx;
  logic [1:0]         code;
  logic               a_vld;
  logic signed [15:0] a_ct, a_st, a_cp, a_sp;
  logic [1:0]         a_code;
  logic               a_last;
  logic               b_vld;
  logic signed [15:0] b_nx, b_ny, b_nz;
  logic [1:0]         b_code;
  logic               b_last;
  logic               c_vld;
  logic signed [17:0] c_px, c_py, c_pz;
  logic signed [15:0] c_nx, c_ny, c_nz;
  logic [1:0]         c_code;
  logic               c_last;
  logic signed [16:0] rad;
  logic signed [18:0] sx, sy, sz;
  logic signed [17:0] nx_w, ny_w;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) return 16'sh7fff;
    if (v < -19'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  assign en = !out_valid || out_ready;
  assign pop = en && !fifo_empty && vtx == 3'd5;
  assign code = usct_pkg::corner_of(vtx);
  assign rad = $signed({2'b00, sphere_radius});
  assign nx_w = usct_pkg::mul_round15(17'(a_ct), 17'(a_sp));
  assign ny_w = usct_pkg::mul_round15(17'(a_st), 17'(a_sp));
  assign sx = 19'(center_x) + 19'(c_px);
  assign sy = 19'(center_y) + 19'(c_py);
  assign sz = 19'(center_z) + 19'(c_pz);

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx <= 3'd0;
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_vld <= !fifo_empty;
      b_vld <= a_vld;
      c_vld <= b_vld;
      out_valid <= c_vld;
      if (!fifo_empty) vtx <= (vtx == 3'd5) ? 3'd0 : vtx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ct <= code[0] ? fifo_data.ct1 : fifo_data.ct0;
      a_st <= code[0] ? fifo_data.st1 : fifo_data.st0;
      a_cp <= code[1] ? fifo_data.cp1 : fifo_data.cp0;
      a_sp <= code[1] ? fifo_data.sp1 : fifo_data.sp0;
      a_code <= code;
      a_last <= vtx == 3'd5;
      b_nx <= nx_w[15:0];
      b_ny <= ny_w[15:0];
      b_nz <= a_cp;
      b_code <= a_code;
      b_last <= a_last;
      c_px <= usct_pkg::mul_round15(rad, 17'(b_nx));
      c_py <= usct_pkg::mul_round15(rad, 17'(b_ny));
      c_pz <= usct_pkg::mul_round15(rad, 17'(b_nz));
      c_nx <= b_nx;
      c_ny <= b_ny;
      c_nz <= b_nz;
      c_code <= b_code;
      c_last <= b_last;
      pos_x <= sat16(sx);
      pos_y <= sat16(sy);
      pos_z <= sat16(sz);
      normal_x <= c_nx;
      normal_y <= c_ny;
      normal_z <= c_nz;
      corner_code <= c_code;
      last_vertex <= c_last;
    end
  end

endmodule

/* src/uv_sphere_cell_tessellator_unit.sv */
// Top level of the sphere cell tessellator: registers, front end, queue and back end.
//
//   Channel  Direction  Handshake              Payload
//   cfg      in         cfg_write              cfg_index, cfg_data
//   in       in         in_valid / in_ready    theta_index, phi_index
//   out      out        out_valid / out_ready  pos_*, normal_*, corner_code, last_vertex
//
// A new cell is taken only once the corner angle divider, which retires five quotient bits
// per cycle, has passed the corner angles of the previous cell on to the sine issue.
// The back end sends one vertex per cycle when not stalled, six per cell.
// The sine pipelines stall only when the two-entry queue is full; the back end stalls on out_ready.
// Reset is synchronous and clears all control state and loads the register defaults.
`timescale 1ns / 1ps

module uv_sphere_cell_tessellator_unit #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [9:0]         theta_index,
  input  logic [9:0]         phi_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [1:0]         corner_code,
  output logic               last_vertex
);

  logic [14:0]        sphere_radius;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic signed [15:0] center_z;
  logic [10:0]        theta_count;
  logic [10:0]        phi_count;

  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  usct_pkg::trig_t    push_data;
  usct_pkg::trig_t    pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 15'd256;
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      theta_count <= 11'd16;
      phi_count <= 11'd8;
    end else if (cfg_write) begin
      case (cfg_index)
        usct_pkg::REG_RADIUS:   sphere_radius <= cfg_data[14:0];
        usct_pkg::REG_CENTER_X: center_x <= cfg_data;
        usct_pkg::REG_CENTER_Y: center_y <= cfg_data;
        usct_pkg::REG_CENTER_Z: center_z <= cfg_data;
        usct_pkg::REG_THETA_N:  theta_count <= cfg_data[10:0];
        usct_pkg::REG_PHI_N:    phi_count <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  usct_front #(.MAX_SEGMENTS(MAX_SEGMENTS), .ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk(clk), .rst(rst), .theta_count(theta_count), .phi_count(phi_count),
    .in_valid(in_valid), .in_ready(in_ready), .theta_index(theta_index),
    .phi_index(phi_index), .fifo_full(full), .push(push), .push_data(push_data)
  );

  usct_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .pop_data(pop_data), .full(full), .empty(empty)
  );

  usct_back u_back (
    .clk(clk), .rst(rst), .sphere_radius(sphere_radius), .center_x(center_x),
    .center_y(center_y), .center_z(center_z), .fifo_empty(empty), .fifo_data(pop_data),
    .pop(pop), .out_valid(out_valid), .out_ready(out_ready), .pos_x(pos_x),
    .pos_y(pos_y), .pos_z(pos_z), .normal_x(normal_x), .normal_y(normal_y),
    .normal_z(normal_z), .corner_code(corner_code), .last_vertex(last_vertex)
  );

endmodule

/* dv/usct_checker.sv */
// Checker for the sphere cell tessellator: predicts the six vertices of each cell and compares.
`timescale 1ns / 1ps

module usct_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [9:0]         theta_index,
  input  logic [9:0]         phi_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [1:0]         corner_code,
  input  logic               last_vertex,
  output int                 error_count,
  output int                 pending_count
);

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [1:0]         corner;
    logic               last;
  } vertex_t;

  vertex_t vertex_queue[$];
  logic [14:0] radius_q;
  logic signed [15:0] cx_q, cy_q, cz_q;
  logic [10:0] theta_n_q, phi_n_q;

  assign pending_count = vertex_queue.size();

  function automatic longint quarter_sine(longint r);
    longint u, u2, t, s;
    u = r << 16;
    u2 = (u * u) >>> 30;
    t = 172272;
    t = 5026994 - ((u2 * t) >>> 30);
    t = 85569303 - ((u2 * t) >>> 30);
    t = 693598669 - ((u2 * t) >>> 30);
    t = 1686629713 - ((u2 * t) >>> 30);
    s = (u * t) >>> 30;
    s = (s + 16384) >>> 15;
    if (s > 32767) s = 32767;
    return s;
  endfunction

  function automatic longint turn_sine(longint a);
    longint r;
    a = a & 16'hFFFF;
    r = a & 16'h3FFF;
    case (a >> 14)
      0: return quarter_sine(r);
      1: return quarter_sine(16384 - r);
      2: return -quarter_sine(r);
      default: return -quarter_sine(16384 - r);
    endcase
  endfunction

  function automatic longint round_product(longint a, longint b);
    longint m;
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 16384) >> 15;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint clamp16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic vertex_t corner_vertex(longint ta, longint pa, logic [1:0] c, logic l);
    vertex_t v;
    longint ct, st, cp, sp, nx, ny;
    ct = turn_sine(ta + 16384);
    st = turn_sine(ta);
    cp = turn_sine(pa + 16384);
    sp = turn_sine(pa);
    nx = round_product(ct, sp);
    ny = round_product(st, sp);
    v.nx = 16'(nx);
    v.ny = 16'(ny);
    v.nz = 16'(cp);
    v.px = 16'(clamp16(longint'(cx_q) + round_product(longint'(radius_q), nx)));
    v.py = 16'(clamp16(longint'(cy_q) + round_product(longint'(radius_q), ny)));
    v.pz = 16'(clamp16(longint'(cz_q) + round_product(longint'(radius_q), cp)));
    v.corner = c;
    v.last = l;
    return v;
  endfunction

  task automatic add_vertex(vertex_t v);
    vertex_queue.insert(vertex_queue.size(), v);
  endtask

  task automatic predict_cell(longint t, longint p);
    longint tc, pc, t0, t1, p0, p1;
    tc = theta_n_q == 0 ? 1 : (theta_n_q > 1024 ? 1024 : theta_n_q);
    pc = phi_n_q == 0 ? 1 : (phi_n_q > 1024 ? 1024 : phi_n_q);
    t0 = ((t * 65536) / tc) & 16'hFFFF;
    t1 = (((t + 1) * 65536) / tc) & 16'hFFFF;
    p0 = ((p * 32768) / pc) & 16'hFFFF;
    p1 = (((p + 1) * 32768) / pc) & 16'hFFFF;
    add_vertex(corner_vertex(t0, p0, usct_pkg::CORNER_00, 1'b0));
    add_vertex(corner_vertex(t1, p0, usct_pkg::CORNER_10, 1'b0));
    add_vertex(corner_vertex(t0, p1, usct_pkg::CORNER_01, 1'b0));
    add_vertex(corner_vertex(t0, p1, usct_pkg::CORNER_01, 1'b0));
    add_vertex(corner_vertex(t1, p0, usct_pkg::CORNER_10, 1'b0));
    add_vertex(corner_vertex(t1, p1, usct_pkg::CORNER_11, 1'b1));
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    vertex_t want;
    if (rst) begin
      error_count = 0;
      radius_q <= 15'd256;
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      theta_n_q <= 11'd16;
      phi_n_q <= 11'd8;
      vertex_queue.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          usct_pkg::REG_RADIUS:   radius_q <= cfg_data[14:0];
          usct_pkg::REG_CENTER_X: cx_q <= cfg_data;
          usct_pkg::REG_CENTER_Y: cy_q <= cfg_data;
          usct_pkg::REG_CENTER_Z: cz_q <= cfg_data;
          usct_pkg::REG_THETA_N:  theta_n_q <= cfg_data[10:0];
          usct_pkg::REG_PHI_N:    phi_n_q <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (vertex_queue.size() == 0) begin
          report_mismatch("unexpected vertex", 0, 0);
        end else begin
          want = vertex_queue.pop_front();
          if (pos_x !== want.px) report_mismatch("pos_x", pos_x, want.px);
          if (pos_y !== want.py) report_mismatch("pos_y", pos_y, want.py);
          if (pos_z !== want.pz) report_mismatch("pos_z", pos_z, want.pz);
          if (normal_x !== want.nx) report_mismatch("normal_x", normal_x, want.nx);
          if (normal_y !== want.ny) report_mismatch("normal_y", normal_y, want.ny);
          if (normal_z !== want.nz) report_mismatch("normal_z", normal_z, want.nz);
          if (corner_code !== want.corner) report_mismatch("corner", corner_code, want.corner);
          if (last_vertex !== want.last) report_mismatch("last", last_vertex, want.last);
        end
      end
      if (in_valid && in_ready) predict_cell(theta_index, phi_index);
    end
  end
endmodule

/* dv/tb_uv_sphere_cell_tessellator_unit.sv */
// Top of the sphere cell tessellator testbench: stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module tb_uv_sphere_cell_tessellator_unit;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [9:0] theta_index = '0;
  logic [9:0] phi_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] pos_x, pos_y, pos_z, normal_x, normal_y, normal_z;
  logic [1:0] corner_code;
  logic last_vertex;
  int error_count, pending_count;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_request = 1'b0;
  logic hold_taken = 1'b0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  uv_sphere_cell_tessellator_unit u_dut (.*);

  usct_checker u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= 200;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_cell(logic [9:0] t, logic [9:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    theta_index <= t;
    phi_index <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_cells(int n, int tn, int pn);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_cell(10'($urandom), 10'($urandom));
      else send_cell(10'($urandom_range(tn - 1)), 10'($urandom_range(pn - 1)));
    end
  endtask

  initial begin
    int tn, pn;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_cell(10'd0, 10'd0);
    send_cell(10'd15, 10'd7);
    send_cell(10'h3FF, 10'h3FF);
    send_cell(10'd5, 10'd3);
    drain();
    write_reg(usct_pkg::REG_RADIUS, 16'h7FFF);
    write_reg(usct_pkg::REG_CENTER_X, 16'h7FFF);
    write_reg(usct_pkg::REG_CENTER_Y, 16'h8000);
    write_reg(usct_pkg::REG_CENTER_Z, 16'h7F00);
    write_reg(usct_pkg::REG_THETA_N, 16'd0);
    write_reg(usct_pkg::REG_PHI_N, 16'd0);
    send_cell(10'd0, 10'd0);
    send_cell(10'd1, 10'd1);
    send_cell(10'h2AA, 10'h155);
    drain();
    write_reg(usct_pkg::REG_RADIUS, 16'd0);
    write_reg(usct_pkg::REG_CENTER_X, 16'h8000);
    write_reg(usct_pkg::REG_CENTER_Y, 16'h7FFF);
    write_reg(usct_pkg::REG_CENTER_Z, 16'h8000);
    write_reg(usct_pkg::REG_THETA_N, 16'h7FF);
    write_reg(usct_pkg::REG_PHI_N, 16'd1024);
    send_cell(10'd0, 10'd0);
    send_cell(10'd1023, 10'd1023);
    send_cell(10'd512, 10'd511);
    drain();
    write_reg(usct_pkg::REG_THETA_N, 16'd1);
    write_reg(usct_pkg::REG_PHI_N, 16'd1);
    write_reg(usct_pkg::REG_RADIUS, 16'd200);
    send_cell(10'd0, 10'd0);
    send_cell(10'd3, 10'd2);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      tn = $urandom_range(1, 64);
      pn = $urandom_range(1, 32);
      write_reg(usct_pkg::REG_RADIUS, 16'($urandom_range(32767)));
      write_reg(usct_pkg::REG_CENTER_X, 16'($urandom));
      write_reg(usct_pkg::REG_CENTER_Y, 16'($urandom));
      write_reg(usct_pkg::REG_CENTER_Z, 16'($urandom));
      write_reg(usct_pkg::REG_THETA_N, 16'(tn));
      write_reg(usct_pkg::REG_PHI_N, 16'(pn));
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 56; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 56; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      if (ph == 0) hold_request = 1'b1;
      random_cells(30, tn, pn);
      drain();
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
